FILE: src/bft_quorum_stage_tracker_assert.svh
// ----------------------------------------------------------------------------
// bft_quorum_stage_tracker_assert.svh
// Assertion macros used by the quorum stage tracker checker.
// ----------------------------------------------------------------------------
`ifndef BFT_QUORUM_STAGE_TRACKER_ASSERT_SVH
`define BFT_QUORUM_STAGE_TRACKER_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define BFTQST_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("bftqst: implication check failed");

// next-cycle implication, disabled while reset is asserted
`define BFTQST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("bftqst: next-cycle check failed");

`endif

FILE: src/bftqst_pkg.sv
// ----------------------------------------------------------------------------
// bftqst_pkg
// Types, codes and helpers for the consensus quorum and stage tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package bftqst_pkg;

	localparam int MAX_PEERS  = 64;
	localparam int SENDER_W   = $clog2(MAX_PEERS);
	localparam int COUNT_W    = $clog2(MAX_PEERS + 1);
	localparam int PEER_W     = 7;
	localparam logic [PEER_W-1:0] PEER_RESET = PEER_W'(4);

	// reciprocal of three for values below 64: (x * 171) >> 9
	localparam int RECIP_SHIFT = 9;
	localparam int RECIP_MUL   = 171;
	localparam int PROD_W      = SENDER_W + 8;

	typedef enum logic [2:0] {
		OP_DB_REQ     = 3'd0,
		OP_CFG_REQ    = 3'd1,
		OP_BAD_REQ    = 3'd2,
		OP_PREPREPARE = 3'd3,
		OP_PREPARE    = 3'd4,
		OP_COMMIT     = 3'd5,
		OP_ADVANCE    = 3'd6,
		OP_BAD_MSG    = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		ERR_OK              = 3'd0,
		ERR_BAD_REQUEST     = 3'd1,
		ERR_TO_INITIAL      = 3'd2,
		ERR_ILLEGAL_COMMIT  = 3'd3,
		ERR_ILLEGAL_EXECUTE = 3'd4,
		ERR_BAD_TYPE        = 3'd5
	} err_t;

	typedef enum logic [1:0] {
		STAGE_PREPARE = 2'd0,
		STAGE_COMMIT  = 2'd1,
		STAGE_EXECUTE = 2'd2
	} stage_t;

	// target stage code that names no stage
	localparam logic [1:0] TARGET_UNKNOWN = 2'd3;

	typedef struct packed {
		op_t                 op;
		logic [SENDER_W-1:0] sender_index;
		logic [1:0]          target_stage;
	} req_t;

	typedef struct packed {
		err_t               error_code;
		stage_t             stage_now;
		logic               req_recorded;
		logic               is_config_request;
		logic               preprepared;
		logic               prepared;
		logic               committed;
		logic [COUNT_W-1:0] prepare_count;
		logic [COUNT_W-1:0] commit_count;
	} rsp_t;

	// twice the fault bound, 2 * ((clamped peer count - 1) / 3)
	function automatic logic [COUNT_W-1:0] quorum_thresh(input logic [PEER_W-1:0] peers);
		logic [SENDER_W-1:0] x;
		logic [PROD_W-1:0]   prod;
		logic [COUNT_W-1:0]  f;
		if (peers == '0) begin
			x = '0;
		end else if (peers > PEER_W'(MAX_PEERS)) begin
			x = SENDER_W'(MAX_PEERS - 1);
		end else begin
			x = SENDER_W'(peers - PEER_W'(1));
		end
		prod = PROD_W'(x) * PROD_W'(RECIP_MUL);
		f    = COUNT_W'(prod >> RECIP_SHIFT);
		return COUNT_W'({f, 1'b0});
	endfunction

endpackage

`default_nettype wire

FILE: src/bftqst_state.sv
// ----------------------------------------------------------------------------
// bftqst_state
// Vote masks, distinct-voter counts, request and stage state; computes the
// response for one request from the current state and commits the update.
// ----------------------------------------------------------------------------
`default_nettype none

module bftqst_state (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bftqst_pkg::PEER_W-1:0] cfg_peers,
	input  logic                          step,
	input  bftqst_pkg::req_t              item,
	output bftqst_pkg::rsp_t              result
);
	import bftqst_pkg::*;

	logic [MAX_PEERS-1:0] prep_votes_q, prep_votes_n;
	logic [MAX_PEERS-1:0] commit_votes_q, commit_votes_n;
	logic [COUNT_W-1:0]   prep_cnt_q, prep_cnt_n;
	logic [COUNT_W-1:0]   commit_cnt_q, commit_cnt_n;
	logic [COUNT_W-1:0]   thresh_q;
	logic                 preprep_q, preprep_n;
	logic                 req_flag_q, req_flag_n;
	logic                 req_kind_q, req_kind_n;
	stage_t               stage_q, stage_n;
	err_t                 err;
	logic                 committed_now;
	logic                 prep_quorum_n, commit_quorum_n, prepared_n;

	// commit check for execute uses the state before this request
	assign committed_now = req_flag_q && preprep_q && (prep_cnt_q > thresh_q)
		&& (commit_cnt_q > thresh_q);

	// decode the request and form the next state
	always_comb begin
		prep_votes_n   = prep_votes_q;
		commit_votes_n = commit_votes_q;
		prep_cnt_n     = prep_cnt_q;
		commit_cnt_n   = commit_cnt_q;
		preprep_n      = preprep_q;
		req_flag_n     = req_flag_q;
		req_kind_n     = req_kind_q;
		stage_n        = stage_q;
		err            = ERR_OK;
		unique case (item.op)
			OP_DB_REQ: begin
				req_flag_n = 1'b1;
				req_kind_n = 1'b0;
			end
			OP_CFG_REQ: begin
				req_flag_n = 1'b1;
				req_kind_n = 1'b1;
			end
			OP_BAD_REQ: begin
				err = ERR_BAD_REQUEST;
			end
			OP_PREPREPARE: begin
				preprep_n = 1'b1;
			end
			OP_PREPARE: begin
				// count a sender only on its first vote
				if (!prep_votes_q[item.sender_index]) begin
					prep_votes_n[item.sender_index] = 1'b1;
					prep_cnt_n = prep_cnt_q + COUNT_W'(1);
				end
			end
			OP_COMMIT: begin
				if (!commit_votes_q[item.sender_index]) begin
					commit_votes_n[item.sender_index] = 1'b1;
					commit_cnt_n = commit_cnt_q + COUNT_W'(1);
				end
			end
			OP_ADVANCE: begin
				case (item.target_stage)
					STAGE_PREPARE: begin
						err = ERR_TO_INITIAL;
					end
					STAGE_COMMIT: begin
						if (!preprep_q || stage_q != STAGE_PREPARE) begin
							err = ERR_ILLEGAL_COMMIT;
						end else begin
							stage_n = STAGE_COMMIT;
						end
					end
					STAGE_EXECUTE: begin
						if (!committed_now || stage_q != STAGE_COMMIT) begin
							err = ERR_ILLEGAL_EXECUTE;
						end else begin
							stage_n = STAGE_EXECUTE;
						end
					end
					TARGET_UNKNOWN: begin
						err = ERR_BAD_TYPE;
					end
					default: begin
						err = ERR_BAD_TYPE;
					end
				endcase
			end
			OP_BAD_MSG: begin
				err = ERR_BAD_TYPE;
			end
			default: begin
				err = ERR_BAD_TYPE;
			end
		endcase
	end

	// response shows the state after the request
	assign prep_quorum_n   = prep_cnt_n > thresh_q;
	assign commit_quorum_n = commit_cnt_n > thresh_q;
	assign prepared_n      = req_flag_n && preprep_n && prep_quorum_n;

	always_comb begin
		result.error_code        = err;
		result.stage_now         = stage_n;
		result.req_recorded      = req_flag_n;
		result.is_config_request = req_flag_n && req_kind_n;
		result.preprepared       = preprep_n;
		result.prepared          = prepared_n;
		result.committed         = prepared_n && commit_quorum_n;
		result.prepare_count     = prep_cnt_n;
		result.commit_count      = commit_cnt_n;
	end

	// hold the quorum threshold; recompute it on a configuration write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= quorum_thresh(PEER_RESET);
		end else if (cfg_we) begin
			thresh_q <= quorum_thresh(cfg_peers);
		end
	end

	// advance the tracker state once per processed request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prep_votes_q   <= '0;
			commit_votes_q <= '0;
			prep_cnt_q     <= '0;
			commit_cnt_q   <= '0;
			preprep_q      <= 1'b0;
			req_flag_q     <= 1'b0;
			req_kind_q     <= 1'b0;
			stage_q        <= STAGE_PREPARE;
		end else if (step) begin
			prep_votes_q   <= prep_votes_n;
			commit_votes_q <= commit_votes_n;
			prep_cnt_q     <= prep_cnt_n;
			commit_cnt_q   <= commit_cnt_n;
			preprep_q      <= preprep_n;
			req_flag_q     <= req_flag_n;
			req_kind_q     <= req_kind_n;
			stage_q        <= stage_n;
		end
	end

endmodule

`default_nettype wire

FILE: src/bft_quorum_stage_tracker.sv
// ----------------------------------------------------------------------------
// bft_quorum_stage_tracker: consensus quorum and stage tracker, one op
// Flow: an accepted request is held in the request register, then moves on
// into the response register, when that is free, with its response.
// Throughput: one request per cycle while responses are taken.
// Reset: all vote, request and stage state cleared; peer count back to 4.
// ----------------------------------------------------------------------------
`default_nettype none

module bft_quorum_stage_tracker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  bftqst_pkg::req_t              req,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output bftqst_pkg::rsp_t              rsp,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bftqst_pkg::PEER_W-1:0] cfg_data
);
	import bftqst_pkg::*;

	logic valid_s1;
	req_t req_s1;
	logic rsp_valid_q;
	rsp_t rsp_q;
	rsp_t result;
	logic adv;

	// move the held request into the response register when it is free
	assign adv       = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || adv;
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	bftqst_state u_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid),
		.cfg_peers (cfg_data),
		.step      (adv),
		.item      (req_s1),
		.result    (result)
	);

	// hold the accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_valid && req_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
	end

	// hold the response until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q <= result;
		end
	end

endmodule

`default_nettype wire

FILE: src/bftqst_checker.sv
// ----------------------------------------------------------------------------
// bftqst_checker
// Port-level checks on the tracker responses, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bft_quorum_stage_tracker_assert.svh"

module bftqst_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             rsp_valid,
	input logic             rsp_ready,
	input bftqst_pkg::rsp_t rsp
);
	import bftqst_pkg::*;

	// committed needs prepared
	`BFTQST_ASSERT_IMPLY(a_commit_needs_prepare, clk, arst_n, rsp_valid && rsp.committed, rsp.prepared)

	// prepared needs a recorded request and a pre-prepare
	`BFTQST_ASSERT_IMPLY(a_prepare_needs_req, clk, arst_n, rsp_valid && rsp.prepared, rsp.req_recorded && rsp.preprepared)

	// error code is always one of the defined codes
	`BFTQST_ASSERT_IMPLY(a_err_known, clk, arst_n, rsp_valid, rsp.error_code <= ERR_BAD_TYPE)

	// a stalled response holds
	`BFTQST_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

endmodule

bind bft_quorum_stage_tracker bftqst_checker u_bftqst_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

`default_nettype wire
